[hw/rtl/hfi_square_wave_angle_pll_macros.svh]
// Assertion macros for the square-wave HFI angle PLL checker.
// No dependencies.
`ifndef HFI_SQUARE_WAVE_ANGLE_PLL_MACROS_SVH
`define HFI_SQUARE_WAVE_ANGLE_PLL_MACROS_SVH
// implication check, disabled in reset
`define HFI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication check, disabled in reset
`define HFI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/hswap_pkg.sv]
// Package for the square-wave HFI angle PLL: types, constants, CORDIC table.
// No dependencies.
package hswap_pkg;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN          = 24;
  localparam int CFG_IDX_W        = 3;
  localparam logic [31:0] INV_K   = 32'h26DD3B6A;

  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_W  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_G = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_G  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_INIT, ST_SC_ITER, ST_ERR_M1, ST_ERR_M2, ST_PI_M1, ST_PI_M2,
    ST_LPF_M1, ST_LPF_M2, ST_ANG_M, ST_LAG_M, ST_AT_ITER, ST_OUT
  } state_t;

  typedef enum logic [1:0] {CR_ROTATE, CR_VECTOR} cr_mode_t;

  typedef struct packed {
    logic     start;
    cr_mode_t mode;
  } cr_ctl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage

[hw/rtl/hswap_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on hswap_pkg.
module hswap_cordic import hswap_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cr_ctl_t            ctl,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] z_in,
  output logic signed [33:0] x_out,
  output logic signed [33:0] y_out,
  output logic signed [33:0] z_out,
  output logic               done
);
  localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               busy_r, busy_nxt;
  cr_mode_t           mode_r;
  logic               pos;
  logic signed [33:0] xs, ys, at;

  always_comb begin
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    at  = $signed({2'b00, atan_turn(i_r)});
    pos = (mode_r == CR_ROTATE) ? !z_r[33] : (y_r > 0);
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r; busy_nxt = busy_r;
    if (ctl.start) begin
      x_nxt = x_in; y_nxt = y_in; z_nxt = z_in; i_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mode_r == CR_ROTATE) begin
        x_nxt = pos ? x_r - ys : x_r + ys;
        y_nxt = pos ? y_r + xs : y_r - xs;
        z_nxt = pos ? z_r - at : z_r + at;
      end else begin
        x_nxt = pos ? x_r + ys : x_r - ys;
        y_nxt = pos ? y_r - xs : y_r + xs;
        z_nxt = pos ? z_r + at : z_r - at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSTEP - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
      mode_r <= CR_ROTATE;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
      if (ctl.start) mode_r <= ctl.mode;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign done  = !busy_r && !ctl.start;
endmodule

[hw/rtl/hfi_square_wave_angle_pll.sv]
// Square-wave HFI angle observer with quadrature PLL. An input beat runs through setup,
// two CORDIC passes, eight passes through the shared multiplier and output; no new beat
// is taken until the last one has loaded the output register, which holds a result
// while the next item runs; only the next result's load waits on out_tready.
// Synchronous active-low reset clears the control, filter and PLL state and loads register
// defaults; the datapath registers and the CORDIC data are not reset.
module hfi_square_wave_angle_pll import hswap_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // alpha_current[15:0], beta_current[31:16], injection_positive[32], zero fill
  input  logic [39:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // rotor_angle[15:0], compensated_angle[31:16], speed_filtered[63:32],
  // alpha_fundamental[79:64], beta_fundamental[95:80]
  output logic [95:0]          out_tdata
);
  logic [15:0] kp_r, ki_r, nw_r, ow_r, sg_r, lg_r;
  state_t state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] pa_r, pb_r;
  logic signed [SAMPLE_BITS:0]   pah_r, pbh_r;
  logic signed [SAMPLE_BITS+1:0] ea_r, eb_r;
  logic signed [15:0] fa_r, fb_r;
  logic signed [31:0] perr_r, err_r, spd_r, sm_r;
  logic [31:0] acc_r, lag_r;
  logic flip_r;
  logic signed [33:0] sin_r;
  logic signed [66:0] prod_r, acc64_r;
  logic signed [33:0] ma_r, mb_r;
  logic [95:0] otd_r;
  logic ov_r;

  cr_ctl_t cctl;
  logic signed [33:0] cxi, cyi, czi, cxo, cyo, czo;
  logic cdone;

  hswap_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .ctl(cctl), .x_in(cxi), .y_in(cyi), .z_in(czi),
    .x_out(cxo), .y_out(cyo), .z_out(czo), .done(cdone));

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] a_in, b_in;
  logic signed [SAMPLE_BITS:0]   da, db;
  logic signed [SAMPLE_BITS+1:0] ha, hb;
  logic signed [SAMPLE_BITS:0]   sa, sb;
  logic [31:0] tflip;
  logic signed [66:0] m_out;
  logic signed [66:0] dsh;
  logic signed [31:0] mag;

  assign a_in  = in_tdata[SAMPLE_BITS-1:0];
  assign b_in  = in_tdata[16+SAMPLE_BITS-1:16];
  assign da    = a_in - pa_r;
  assign db    = b_in - pb_r;
  assign ha    = da - pah_r;
  assign hb    = db - pbh_r;
  assign sa    = a_in + pa_r;
  assign sb    = b_in + pb_r;
  assign tflip = acc_r + 32'h80000000;
  assign m_out = ma_r * mb_r;
  assign dsh   = acc64_r >>> 16;
  assign mag   = spd_r[31] ? -spd_r : spd_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = otd_r;

  always_comb begin
    state_nxt = state_r;
    cctl = '{start: 1'b0, mode: CR_ROTATE};
    cxi = $signed({2'b00, INV_K}); cyi = '0;
    czi = flip_r ? $signed({{2{tflip[31]}}, tflip}) : $signed({{2{acc_r[31]}}, acc_r});
    case (state_r)
      ST_IDLE:    if (in_tvalid && in_tready) state_nxt = ST_SC_INIT;
      ST_SC_INIT: begin cctl.start = 1'b1; state_nxt = ST_SC_ITER; end
      ST_SC_ITER: if (cdone) state_nxt = ST_ERR_M1;
      ST_ERR_M1:  state_nxt = ST_ERR_M2;
      ST_ERR_M2:  state_nxt = ST_PI_M1;
      ST_PI_M1:   state_nxt = ST_PI_M2;
      ST_PI_M2:   state_nxt = ST_LPF_M1;
      ST_LPF_M1:  state_nxt = ST_LPF_M2;
      ST_LPF_M2:  state_nxt = ST_ANG_M;
      ST_ANG_M:   state_nxt = ST_LAG_M;
      ST_LAG_M: begin
        cctl = '{start: 1'b1, mode: CR_VECTOR};
        cxi = 34'sd65536;
        cyi = 34'(m_out >>> 16);
        czi = '0;
        state_nxt = ST_AT_ITER;
      end
      ST_AT_ITER: if (cdone) state_nxt = ST_OUT;
      ST_OUT:     if (!ov_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      kp_r <= '0; ki_r <= '0; nw_r <= 16'd6554; ow_r <= 16'd58982;
      sg_r <= '0; lg_r <= '0;
      pa_r <= '0; pb_r <= '0; pah_r <= '0; pbh_r <= '0;
      perr_r <= '0; spd_r <= '0; sm_r <= '0; acc_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:     kp_r <= cfg_data;
          REG_KI:     ki_r <= cfg_data;
          REG_NEW_W:  nw_r <= cfg_data;
          REG_OLD_W:  ow_r <= cfg_data;
          REG_STEP_G: sg_r <= cfg_data;
          REG_LAG_G:  lg_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          pa_r <= a_in; pb_r <= b_in; pah_r <= da; pbh_r <= db;
          ea_r <= in_tdata[32] ? -ha : ha;
          eb_r <= in_tdata[32] ? -hb : hb;
          fa_r <= 16'(sa >>> 1);
          fb_r <= 16'(sb >>> 1);
          flip_r <= ((acc_r + 32'h40000000) & 32'h80000000) != 0;
        end
        ST_SC_ITER: if (cdone) begin
          sin_r <= flip_r ? -cyo : cyo;
          ma_r <= 34'(eb_r);
          mb_r <= flip_r ? -cxo : cxo;
        end
        ST_ERR_M1: begin
          prod_r <= m_out; ma_r <= 34'(ea_r); mb_r <= sin_r;
        end
        ST_ERR_M2: begin
          err_r <= sat32((prod_r - m_out) >>> 30);
          ma_r <= $signed({18'd0, kp_r});
          mb_r <= 34'(sat32((prod_r - m_out) >>> 30)) - 34'(perr_r);
        end
        ST_PI_M1: begin
          acc64_r <= m_out <<< 8;
          ma_r <= $signed({18'd0, ki_r}); mb_r <= 34'(err_r);
          perr_r <= err_r;
        end
        ST_PI_M2: begin
          acc64_r <= acc64_r + m_out;
        end
        ST_LPF_M1: begin
          spd_r <= sat32(67'(spd_r) + dsh);
          ma_r <= $signed({18'd0, ow_r}); mb_r <= 34'(sm_r);
        end
        ST_LPF_M2: begin
          acc64_r <= m_out;
          ma_r <= $signed({18'd0, nw_r}); mb_r <= 34'(spd_r);
        end
        ST_ANG_M: begin
          sm_r <= sat32((acc64_r + m_out) >>> 16);
          ma_r <= $signed({18'd0, lg_r}); mb_r <= {2'b00, mag};
        end
        ST_LAG_M: begin
          ma_r <= $signed({18'd0, sg_r}); mb_r <= 34'(spd_r);
        end
        ST_AT_ITER: if (cdone) begin
          lag_r <= czo[31:0];
          acc_r <= acc_r + 32'(m_out >>> 16);
        end
        ST_OUT: if (!ov_r || out_tready) begin
          otd_r <= {fb_r, fa_r, sm_r,
                    16'((acc_r + lag_r) >> (32 - ANGLE_BITS)),
                    16'(acc_r >> (32 - ANGLE_BITS))};
        end
        default: ;
      endcase
    end
  end
endmodule

[hw/rtl/hswap_checker.sv]
// Port-level checker for the HFI angle PLL, bound to the top level.
// Depends on hfi_square_wave_angle_pll_macros.svh.
`include "hfi_square_wave_angle_pll_macros.svh"
module hswap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);
  `HFI_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  `HFI_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `HFI_ASSERT_IMP(a_out_known, clk, rst_n, out_tvalid, !$isunknown(out_tdata), "unknown result bits")
endmodule

bind hfi_square_wave_angle_pll hswap_checker u_hswap_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata);

[tb/hfi_square_wave_angle_pll_test.sv]
// Testbench for the square-wave HFI angle PLL: drives current samples on the input
// stream, predicts every result beat in SystemVerilog and compares it field by field.
// Depends on hswap_pkg and hfi_square_wave_angle_pll.
module hfi_square_wave_angle_pll_test;
  import hswap_pkg::*;

  typedef struct packed {
    logic [15:0] beta_fund;
    logic [15:0] alpha_fund;
    logic [31:0] speed_filt;
    logic [15:0] comp_angle;
    logic [15:0] rotor_angle;
  } pll_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;

  int errors = 0;
  bit idle_on = 1;
  pll_result_t expected_q[$];

  // predictor state and registers
  logic [15:0] r_kp, r_ki, r_new_w, r_old_w, r_step_g, r_lag_g;
  longint p_alpha, p_beta, p_alpha_hf, p_beta_hf;
  int p_err, spd_raw, spd_smooth;
  logic [31:0] angle_acc;

  hfi_square_wave_angle_pll u_dut (.*);

  initial forever #5 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    logic flip;
    logic [31:0] t;
    longint z, x, y, xs, ys;
    flip = ang[31] ^ ang[30];
    t = flip ? ang + 32'h80000000 : ang;
    z = longint'(signed'(t));
    x = longint'(INV_K);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(5'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] atan_of(longint t);
    longint x, y, xs, ys;
    logic [31:0] z;
    x = 65536;
    y = t;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_turn(5'(i));
      end else begin
        x -= ys; y += xs; z -= atan_turn(5'(i));
      end
    end
    return z;
  endfunction

  function automatic pll_result_t track_angle(logic [15:0] ia, logic [15:0] ib, logic inj);
    pll_result_t r;
    longint a, b, sg, da, db, fa, fb, ea, eb, c, s, err, delta, mag;
    logic [31:0] lag, step;
    a = longint'(signed'(ia));
    b = longint'(signed'(ib));
    sg = inj ? -1 : 1;
    da = a - p_alpha;
    db = b - p_beta;
    fa = (a + p_alpha) >>> 1;
    fb = (b + p_beta) >>> 1;
    ea = (da - p_alpha_hf) * sg;
    eb = (db - p_beta_hf) * sg;
    p_alpha = a; p_beta = b; p_alpha_hf = da; p_beta_hf = db;
    sin_cos(angle_acc, c, s);
    err = sat32((eb * c - ea * s) >>> 30);
    delta = 256 * longint'(r_kp) * (err - longint'(p_err)) + longint'(r_ki) * err;
    spd_raw = int'(sat32(longint'(spd_raw) + (delta >>> 16)));
    spd_smooth = int'(sat32((longint'(r_old_w) * spd_smooth
                             + longint'(r_new_w) * spd_raw) >>> 16));
    p_err = int'(err);
    step = 32'((longint'(spd_raw) * longint'(r_step_g)) >>> 16);
    angle_acc += step;
    mag = spd_raw < 0 ? -longint'(spd_raw) : longint'(spd_raw);
    lag = atan_of((mag * longint'(r_lag_g)) >>> 16);
    r.rotor_angle = angle_acc[31:16];
    r.comp_angle = 16'((angle_acc + lag) >> 16);
    r.speed_filt = spd_smooth;
    r.alpha_fund = fa[15:0];
    r.beta_fund = fb[15:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_KP: r_kp = val;
      REG_KI: r_ki = val;
      REG_NEW_W: r_new_w = val;
      REG_OLD_W: r_old_w = val;
      REG_STEP_G: r_step_g = val;
      REG_LAG_G: r_lag_g = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_sample(logic [15:0] ia, logic [15:0] ib, logic inj);
    if (idle_on && $urandom_range(3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
    in_tvalid = 1;
    in_tdata = {7'b0, inj, ib, ia};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(track_angle(ia, ib, inj));
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic set_gains(logic [15:0] kp, ki, nw, ow, sg, lg);
    drain();
    write_reg(REG_KP, kp); write_reg(REG_KI, ki);
    write_reg(REG_NEW_W, nw); write_reg(REG_OLD_W, ow);
    write_reg(REG_STEP_G, sg); write_reg(REG_LAG_G, lg);
  endtask

  // square-wave response on a rotating rotor with noise
  task automatic send_hfi_run(int n, int amp);
    logic inj;
    int ph;
    logic [15:0] ia, ib;
    inj = 1'($urandom_range(1));
    ph = $urandom;
    for (int k = 0; k < n; k++) begin
      ph += 700;
      ia = 16'((inj ? amp : -amp) * ((ph & 16'h8000) ? 1 : -1) + $urandom_range(63) - 32);
      ib = 16'((inj ? amp : -amp) * ((ph & 16'h4000) ? 1 : -1) + $urandom_range(63) - 32);
      send_sample(ia, ib, inj);
      inj = ~inj;
    end
  endtask

  task automatic test_extremes();
    send_sample(16'h7FFF, 16'h8000, 1);
    send_sample(16'h8000, 16'h7FFF, 0);
    send_sample(16'h7FFF, 16'h7FFF, 1);
    send_sample(16'h8000, 16'h8000, 0);
    send_sample(16'h0000, 16'hFFFF, 1);
    send_sample(16'hFFFF, 16'h0000, 0);
  endtask

  task automatic test_saturation();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int k = 0; k < 8; k++)
      send_sample(k[0] ? 16'h7FFF : 16'h8000, k[1] ? 16'h8000 : 16'h7FFF, k[0]);
    // out-of-range index must be ignored
    drain();
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hABCD);
    send_hfi_run(6, 30000);
  endtask

  task automatic test_zero_gains();
    set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_hfi_run(5, 1000);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      set_gains(16'($urandom_range(2048)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom), 16'($urandom));
      send_hfi_run(120, $urandom_range(30, 20000));
      for (int k = 0; k < 40; k++) send_sample(16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_no_idling();
    idle_on = 0;
    set_gains(16'd300, 16'd900, 16'd6554, 16'd58982, 16'd40000, 16'd3000);
    send_hfi_run(500, 4000);
  endtask

  initial begin
    r_kp = 0; r_ki = 0; r_new_w = 16'd6554; r_old_w = 16'd58982;
    r_step_g = 0; r_lag_g = 0;
    p_alpha = 0; p_beta = 0; p_alpha_hf = 0; p_beta_hf = 0;
    p_err = 0; spd_raw = 0; spd_smooth = 0; angle_acc = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    test_extremes();
    test_zero_gains();
    test_saturation();
    test_random_settings();
    test_no_idling();
    drain();
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(4) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    pll_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        report("unexpected beat", 32'h0, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (got.rotor_angle !== want.rotor_angle)
          report("rotor_angle", got.rotor_angle, want.rotor_angle);
        if (got.comp_angle !== want.comp_angle)
          report("compensated_angle", got.comp_angle, want.comp_angle);
        if (got.speed_filt !== want.speed_filt)
          report("speed_filtered", got.speed_filt, want.speed_filt);
        if (got.alpha_fund !== want.alpha_fund)
          report("alpha_fundamental", got.alpha_fund, want.alpha_fund);
        if (got.beta_fund !== want.beta_fund)
          report("beta_fundamental", got.beta_fund, want.beta_fund);
      end
    end
  end

  initial begin
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/hswap_pkg.sv
hw/rtl/hswap_cordic.sv
hw/rtl/hfi_square_wave_angle_pll.sv
hw/rtl/hswap_checker.sv
tb/hfi_square_wave_angle_pll_test.sv
